// ===== rtl/dmc_pkg.sv =====
// Shared types, sizes and helpers for the direct-mapped cache lookup unit.
// No dependencies; imported by the top level.
package dmc_pkg;

  localparam int ADDR_W         = 8;
  localparam int DATA_W         = 8;
  localparam int COUNT_W        = 16;

  localparam int MEMORY_BYTES   = 256;
  localparam int CACHE_LINES    = 4;
  localparam int WORDS_PER_LINE = 4;

  localparam int OFF_W  = $clog2(WORDS_PER_LINE);
  localparam int LINE_W = $clog2(CACHE_LINES);
  localparam int TAG_W  = ADDR_W - OFF_W - LINE_W;
  localparam int SLOT_W = LINE_W + OFF_W;
  localparam int SLOTS  = CACHE_LINES * WORDS_PER_LINE;
  localparam int MEM_AW = $clog2(MEMORY_BYTES);
  localparam int EXT_W  = (ADDR_W > MEM_AW) ? ADDR_W : MEM_AW;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } out_item_t;

  // Backing memory index: byte address wrapped to the memory size.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
    logic [EXT_W-1:0] wide;
    begin
      wide = EXT_W'(a);
      return wide[MEM_AW-1:0];
    end
  endfunction

  // Saturating increment of a hit or miss count.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    begin
      return (v == COUNT_MAX) ? v : v + 1'b1;
    end
  endfunction

endpackage

// ===== rtl/dmc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; used for the backing memory of the cache unit.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ===== rtl/direct_mapped_cache_lookup_unit.sv =====
// Direct-mapped cache lookup unit: top level with sequencer, tag/line store
// and counters. Depends on dmc_pkg and dmc_ram (backing memory).
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+----------------------
//   in      | in_valid, in_stall, in_item  | to unit   | mode, address, value
//   out     | out_valid, out_stall, out_item | from unit | hit, data, counts
//
// Sequence: a memory write or a cache hit is accepted, then loads the output
//   register; a miss first fills the whole line, one word per cycle from the
//   single backing-memory port, then loads the output register.
// Reset: rst_n (synchronous, active low) invalidates every line, zeroes the
//   tags, the cached words and both counts. The backing memory is not cleared.
// Stalls: the result sits in an output register, so a new item is taken while
//   an earlier result waits; only the response step waits on out_stall.
module direct_mapped_cache_lookup_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dmc_pkg::out_item_t  out_item
);
  import dmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Latched request and lookup outcome
  in_item_t            req_r;
  logic                hit_r;

  // Cache contents
  logic [TAG_W-1:0]    tags_r  [CACHE_LINES];
  logic [CACHE_LINES-1:0] valid_r;
  logic [DATA_W-1:0]   words_r [SLOTS];

  // Fill sequencer: counts issued reads, one more step to catch the last word
  logic [OFF_W:0]      cnt_r, cnt_nxt;
  logic [OFF_W:0]      cnt_prev;

  logic [COUNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // Backing memory port
  logic                ram_we;
  logic [MEM_AW-1:0]   ram_addr;
  logic [DATA_W-1:0]   ram_rdata;

  // Decode of the incoming and the held address
  logic [LINE_W-1:0]   in_line;
  logic [TAG_W-1:0]    in_tag;
  logic                lookup_hit;
  logic [LINE_W-1:0]   req_line;
  logic [TAG_W-1:0]    req_tag;
  logic [OFF_W-1:0]    req_off;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                word_we;
  logic                line_we;
  logic [SLOT_W-1:0]   word_slot;
  logic [SLOT_W-1:0]   read_slot;
  logic                req_access;

  assign in_line    = in_item.address[OFF_W +: LINE_W];
  assign in_tag     = in_item.address[ADDR_W-1 -: TAG_W];
  assign lookup_hit = valid_r[in_line] && (tags_r[in_line] == in_tag);

  assign req_line   = req_r.address[OFF_W +: LINE_W];
  assign req_tag    = req_r.address[ADDR_W-1 -: TAG_W];
  assign req_off    = req_r.address[OFF_W-1:0];
  assign req_access = (req_r.mode == MODE_ACCESS);

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;

  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;

  assign cnt_prev   = cnt_r - 1'b1;
  assign word_slot  = {req_line, cnt_prev[OFF_W-1:0]};
  assign read_slot  = {req_line, req_off};

  dmc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEMORY_BYTES)
  ) u_backing_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_item.write_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_load      = 1'b0;
    word_we       = 1'b0;
    line_we       = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = mem_index({req_tag, req_line, cnt_r[OFF_W-1:0]});
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        ram_addr = mem_index(in_item.address);
        if (in_acc) begin
          if (in_item.mode == MODE_WRITE) begin
            // Store the byte now; the cache is left as it is
            ram_we    = 1'b1;
            state_nxt = S_RESP;
          end else if (lookup_hit) begin
            state_nxt = S_RESP;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_FILL;
          end
        end
      end

      S_FILL: begin
        // Read word cnt_r, capture word cnt_r-1 as it returns
        word_we = (cnt_r != '0);
        if (cnt_r == (OFF_W+1)'(WORDS_PER_LINE)) begin
          line_we   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_RESP: begin
        if (req_access) begin
          if (hit_r) begin
            hit_cnt_nxt = sat_inc(hit_cnt_r);
          end else begin
            miss_cnt_nxt = sat_inc(miss_cnt_r);
          end
        end
        out_item_nxt.hit        = req_access && hit_r;
        out_item_nxt.read_data  = req_access ? words_r[read_slot] : '0;
        out_item_nxt.hit_count  = hit_cnt_nxt;
        out_item_nxt.miss_count = miss_cnt_nxt;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // Hold until the output register frees up
          hit_cnt_nxt  = hit_cnt_r;
          miss_cnt_nxt = miss_cnt_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      tags_r      <= '{default: '0};
      words_r     <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        req_r <= in_item;
        hit_r <= lookup_hit;
      end
      if (word_we) begin
        words_r[word_slot] <= ram_rdata;
      end
      if (line_we) begin
        tags_r[req_line]  <= req_tag;
        valid_r[req_line] <= 1'b1;
      end
      if (out_load) begin
        out_item_r <= out_item_nxt;
      end
    end
  end

endmodule
